// ===== src/srgb_to_xyz_pixel_macros.svh =====
// Assertion macros shared by the sRGB to XYZ pixel converter.
`ifndef SRGB_TO_XYZ_PIXEL_MACROS_SVH
`define SRGB_TO_XYZ_PIXEL_MACROS_SVH

`ifndef SYNTHESIS
`define S2XYZ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s2xyz check failed");
`define S2XYZ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s2xyz check failed");
`else
`define S2XYZ_ASSERT_SAME(lbl, ante, cons)
`define S2XYZ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/s2xyz_pkg.sv =====
// Shared types, constants and the linearization table of the sRGB to XYZ converter.
`default_nettype none

package s2xyz_pkg;

  localparam int CH_W     = 8;
  localparam int N_CODES  = 1 << CH_W;
  localparam int N_CH     = 3;
  localparam int LIN_W    = 31;
  localparam int COEF_W   = 14;
  localparam int SUM_W    = 44;
  localparam int OUT_W    = 15;
  localparam int OUT_FRAC_BITS_DEF = 8;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;
  localparam int NSTG     = 6;

  localparam logic [63:0]  Q_ONE    = 64'd1 << 30;
  localparam logic [63:0]  LOW_DEN  = 64'd32946;
  localparam logic [127:0] HIGH_DEN = 128'd269025 * 128'd269025;

  typedef logic [LIN_W-1:0] lin_tab_t [N_CODES];
  typedef logic [LIN_W-1:0] lin_vec_t [N_CH];
  typedef logic [SUM_W-1:0] sum_vec_t [N_CH];
  typedef logic [OUT_W-1:0] res_vec_t [N_CH];

  // per-stage load enables, first stage to last
  typedef struct packed {
    logic lin;
    logic prod;
    logic sum;
    logic rnd;
    logic mul;
    logic res;
  } adv_t;

  localparam logic [COEF_W-1:0] COEF [N_CH][N_CH] = '{
    '{14'd4124, 14'd3576, 14'd1805},
    '{14'd2126, 14'd7152, 14'd722},
    '{14'd193,  14'd1192, 14'd9505}
  };

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  function automatic logic [63:0] pow5q(input logic [63:0] r);
    logic [63:0] r2;
    r2 = qmul(r, r);
    return qmul(qmul(r2, r2), r);
  endfunction

  // Q30 linear value of one code: 2.4 power as square times fifth root
  function automatic logic [LIN_W-1:0] lin_entry(input int v);
    logic [63:0]  n;
    logic [63:0]  a;
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] num;
    logic [63:0]  res;
    if (v <= 10) begin
      res = ((64'(10 * v) << 30) + 64'd16473) / LOW_DEN;
    end else begin
      n   = 64'(1000 * v + 14025);
      num = 128'(n * n) << 30;
      a   = 64'(num / HIGH_DEN);
      r   = '0;
      for (int b = 30; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (c <= Q_ONE) begin
          if (pow5q(c) <= a) begin
            r = c;
          end
        end
      end
      res = qmul(a, r);
    end
    return res[LIN_W-1:0];
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t t;
    for (int v = 0; v < N_CODES; v++) begin
      t[v] = lin_entry(v);
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

endpackage

`default_nettype wire

// ===== src/srgb_to_xyz_pixel.sv =====
// Top level of the sRGB to CIE XYZ (D65) pixel converter.
//
//  channel | ports                 | beat
//  --------+-----------------------+---------------------------------------
//  in      | in_tvalid/tready/...  | red, green, blue codes; tlast = last pixel
//  out     | out_tvalid/tready/... | tri_x, tri_y, tri_z; tlast = end of image
//
// One pixel per cycle while out_tready is high; one register stage each for lookup,
// products, row sums, rounding shift, reciprocal multiply and saturation.
// Each stage has its own valid bit and loads when it is empty or its successor
// moves, so bubbles are squeezed out and a stall on out_tready backs up stage
// by stage. Reset clears only the valid bits.
`default_nettype none
`include "srgb_to_xyz_pixel_macros.svh"

module srgb_to_xyz_pixel #(
  parameter int OUT_FRAC_BITS = s2xyz_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // tri_x[14:0], tri_y[29:15], tri_z[44:30], zero
  output logic             out_tlast
);

  localparam int NSTG = s2xyz_pkg::NSTG;

  logic [NSTG-1:0]     vld_r;
  logic [NSTG-1:0]     last_r;
  logic [NSTG-1:0]     en;
  s2xyz_pkg::adv_t     adv;
  s2xyz_pkg::lin_vec_t lin;
  s2xyz_pkg::sum_vec_t sum;
  s2xyz_pkg::res_vec_t res;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign adv.lin  = en[0];
  assign adv.prod = en[1];
  assign adv.sum  = en[2];
  assign adv.rnd  = en[3];
  assign adv.mul  = en[4];
  assign adv.res  = en[5];

  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      last_r[0] <= in_tlast;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  s2xyz_lin u_lin (
    .clk   (clk),
    .adv   (adv),
    .red   (in_tdata[7:0]),
    .green (in_tdata[15:8]),
    .blue  (in_tdata[23:16]),
    .lin_r (lin)
  );

  s2xyz_mac u_mac (
    .clk   (clk),
    .adv   (adv),
    .lin   (lin),
    .sum_r (sum)
  );

  s2xyz_scale #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_scale (
    .clk   (clk),
    .adv   (adv),
    .sum   (sum),
    .res_r (res)
  );

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tlast  = last_r[NSTG-1];
  assign out_tdata  = {3'b000, res[2], res[1], res[0]};

  `S2XYZ_ASSERT_NEXT(a_accept_fills, in_tvalid && in_tready, vld_r[0])
  `S2XYZ_ASSERT_SAME(a_full_when_blocked, !in_tready, (&vld_r) && !out_tready)
  `S2XYZ_ASSERT_NEXT(a_tail_reaches_out, vld_r[NSTG-2] && en[NSTG-1], out_tvalid)

endmodule

`default_nettype wire

// ===== src/s2xyz_lin.sv =====
// Gamma decode: table lookup of the three channel codes into registered Q30 values.
`default_nettype none

module s2xyz_lin (
  input  wire logic                       clk,
  input  wire s2xyz_pkg::adv_t            adv,
  input  wire logic [s2xyz_pkg::CH_W-1:0] red,
  input  wire logic [s2xyz_pkg::CH_W-1:0] green,
  input  wire logic [s2xyz_pkg::CH_W-1:0] blue,
  output s2xyz_pkg::lin_vec_t             lin_r
);

  always_ff @(posedge clk) begin
    if (adv.lin) begin
      lin_r[0] <= s2xyz_pkg::LIN_TAB[red];
      lin_r[1] <= s2xyz_pkg::LIN_TAB[green];
      lin_r[2] <= s2xyz_pkg::LIN_TAB[blue];
    end
  end

endmodule

`default_nettype wire

// ===== src/s2xyz_mac.sv =====
// Matrix stage: nine registered products, then three registered row sums.
`default_nettype none

module s2xyz_mac (
  input  wire logic                 clk,
  input  wire s2xyz_pkg::adv_t      adv,
  input  wire s2xyz_pkg::lin_vec_t  lin,
  output s2xyz_pkg::sum_vec_t       sum_r
);

  logic [s2xyz_pkg::SUM_W-1:0] prod_r [s2xyz_pkg::N_CH][s2xyz_pkg::N_CH];

  always_ff @(posedge clk) begin
    if (adv.prod) begin
      for (int i = 0; i < s2xyz_pkg::N_CH; i++) begin
        for (int j = 0; j < s2xyz_pkg::N_CH; j++) begin
          prod_r[i][j] <= s2xyz_pkg::SUM_W'(lin[j]) *
                          s2xyz_pkg::SUM_W'(s2xyz_pkg::COEF[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.sum) begin
      for (int i = 0; i < s2xyz_pkg::N_CH; i++) begin
        sum_r[i] <= prod_r[i][0] + prod_r[i][1] + prod_r[i][2];
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/s2xyz_scale.sv =====
// Output scaling: round, divide by 100 * 2^30 via shift and reciprocal, saturate.
`default_nettype none

module s2xyz_scale #(
  parameter int OUT_FRAC_BITS = s2xyz_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire s2xyz_pkg::adv_t      adv,
  input  wire s2xyz_pkg::sum_vec_t  sum,
  output s2xyz_pkg::res_vec_t       res_r
);

  // sum * 2^F / (25 * 2^32): shift by 32, then divide by 25
  localparam int X_W      = s2xyz_pkg::SUM_W + OUT_FRAC_BITS + 1;
  localparam int Y_W      = X_W - 32;
  localparam int RK       = Y_W + 5;
  localparam int RECIP_W  = RK - 4;
  localparam logic [63:0] RECIP = ((64'd1 << RK) + 64'd24) / 64'd25;
  localparam int P_W      = Y_W + RECIP_W;
  localparam int Q_W      = P_W - RK;
  localparam int CMP_W    = (Q_W > s2xyz_pkg::OUT_W) ? Q_W : s2xyz_pkg::OUT_W;
  localparam logic [X_W-1:0] HALF = X_W'(64'd50 << 30);

  logic [Y_W-1:0] y_r    [s2xyz_pkg::N_CH];
  logic [P_W-1:0] prod_r [s2xyz_pkg::N_CH];
  logic [X_W-1:0] x      [s2xyz_pkg::N_CH];
  logic [Q_W-1:0] q      [s2xyz_pkg::N_CH];

  always_comb begin
    for (int i = 0; i < s2xyz_pkg::N_CH; i++) begin
      x[i] = (X_W'(sum[i]) << OUT_FRAC_BITS) + HALF;
      q[i] = prod_r[i][P_W-1:RK];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.rnd) begin
      for (int i = 0; i < s2xyz_pkg::N_CH; i++) begin
        y_r[i] <= x[i][X_W-1:32];
      end
    end
    if (adv.mul) begin
      for (int i = 0; i < s2xyz_pkg::N_CH; i++) begin
        prod_r[i] <= P_W'(y_r[i]) * P_W'(RECIP[RECIP_W-1:0]);
      end
    end
    if (adv.res) begin
      for (int i = 0; i < s2xyz_pkg::N_CH; i++) begin
        if (CMP_W'(q[i]) > CMP_W'(s2xyz_pkg::OUT_MAX)) begin
          res_r[i] <= s2xyz_pkg::OUT_MAX;
        end else begin
          res_r[i] <= s2xyz_pkg::OUT_W'(q[i]);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/srgb_to_xyz_pixel_tb.sv =====
// Testbench for srgb_to_xyz_pixel: random and corner-case pixels checked against a local model.
module srgb_to_xyz_pixel_tb;

  localparam int FRAC_BITS  = s2xyz_pkg::OUT_FRAC_BITS_DEF;
  localparam int OW         = s2xyz_pkg::OUT_W;
  localparam int CW         = s2xyz_pkg::CH_W;
  localparam int HOLD_LEN   = 80;
  localparam int STALL_STOP = 2000;

  typedef struct packed {
    logic [OW-1:0] x;
    logic [OW-1:0] y;
    logic [OW-1:0] z;
    logic          eoi;
  } xyz_t;

  // rows X, Y, Z; coefficients times 1e4
  localparam logic [15:0] MIX [3][3] = '{
    '{16'd4124, 16'd3576, 16'd1805},
    '{16'd2126, 16'd7152, 16'd722},
    '{16'd193,  16'd1192, 16'd9505}
  };

  // {last, blue, green, red}
  localparam logic [24:0] CORNERS [16] = '{
    {1'b0, 8'd0,   8'd0,   8'd0},
    {1'b1, 8'd255, 8'd255, 8'd255},
    {1'b0, 8'd0,   8'd0,   8'd255},
    {1'b0, 8'd0,   8'd255, 8'd0},
    {1'b0, 8'd255, 8'd0,   8'd0},
    {1'b0, 8'd10,  8'd10,  8'd10},
    {1'b0, 8'd11,  8'd11,  8'd11},
    {1'b0, 8'd1,   8'd1,   8'd1},
    {1'b1, 8'd254, 8'd254, 8'd254},
    {1'b0, 8'd12,  8'd11,  8'd10},
    {1'b0, 8'd32,  8'd64,  8'd128},
    {1'b1, 8'd170, 8'd85,  8'd170},
    {1'b0, 8'd85,  8'd170, 8'd85},
    {1'b0, 8'd9,   8'd200, 8'd12},
    {1'b1, 8'd255, 8'd0,   8'd255},
    {1'b0, 8'd255, 8'd255, 8'd255}
  };

  class xyz_scoreboard;
    logic [63:0] lin_lut [256];
    xyz_t        expected_q [$];
    int          errors;

    function new();
      errors = 0;
      for (int v = 0; v < 256; v++) lin_lut[v] = lin_of_code(v);
    endfunction

    function logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
      return (a * b) >> 30;
    endfunction

    // Q30 linear light: x^2.4 as x^2 times fifth root of x^2
    function logic [63:0] lin_of_code(int v);
      logic [63:0]  n;
      logic [63:0]  sq;
      logic [63:0]  root;
      logic [63:0]  c;
      logic [63:0]  c2;
      logic [127:0] num;
      logic [127:0] den;
      if (v <= 10) begin
        return ((64'(10 * v) << 30) + 64'd16473) / 64'd32946;
      end
      n    = 64'(1000 * v + 14025);
      num  = 128'(n * n) << 30;
      den  = 128'd269025 * 128'd269025;
      sq   = 64'(num / den);
      root = '0;
      for (int b = 30; b >= 0; b--) begin
        c = root | (64'd1 << b);
        if (c <= (64'd1 << 30)) begin
          c2 = fix_mul(c, c);
          if (fix_mul(fix_mul(c2, c2), c) <= sq) root = c;
        end
      end
      return fix_mul(sq, root);
    endfunction

    function logic [OW-1:0] to_out(logic [63:0] acc);
      logic [63:0] q;
      q = ((acc << FRAC_BITS) + (64'd50 << 30)) / (64'd100 << 30);
      if (q > 64'h7FFF) q = 64'h7FFF;
      return q[OW-1:0];
    endfunction

    function void note_pixel(logic [CW-1:0] r, logic [CW-1:0] g, logic [CW-1:0] b,
                             logic last);
      logic [63:0] lin [3];
      logic [63:0] acc [3];
      xyz_t        e;
      lin[0] = lin_lut[r];
      lin[1] = lin_lut[g];
      lin[2] = lin_lut[b];
      for (int row = 0; row < 3; row++) begin
        acc[row] = 0;
        for (int col = 0; col < 3; col++) acc[row] += 64'(MIX[row][col]) * lin[col];
      end
      e.x   = to_out(acc[0]);
      e.y   = to_out(acc[1]);
      e.z   = to_out(acc[2]);
      e.eoi = last;
      expected_q.push_back(e);
    endfunction

    function void check_result(xyz_t got);
      xyz_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected beat: x %0d y %0d z %0d last %0b",
                 $time, got.x, got.y, got.z, got.eoi);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.x !== e.x) begin
        $display("%0t tri_x expected %0d actual %0d", $time, e.x, got.x);
        errors++;
      end
      if (got.y !== e.y) begin
        $display("%0t tri_y expected %0d actual %0d", $time, e.y, got.y);
        errors++;
      end
      if (got.z !== e.z) begin
        $display("%0t tri_z expected %0d actual %0d", $time, e.z, got.z);
        errors++;
      end
      if (got.eoi !== e.eoi) begin
        $display("%0t end_of_image expected %0b actual %0b", $time, e.eoi, got.eoi);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;

  xyz_scoreboard sb = new();
  bit src_gaps = 1'b1;
  bit snk_gaps = 1'b1;
  int hold_reqs = 0;
  int holds_done = 0;
  int idle_cycles = 0;

  srgb_to_xyz_pixel #(.OUT_FRAC_BITS(FRAC_BITS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
    while (src_gaps && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // weighted toward the linear segment and the ends of the range
  function automatic logic [7:0] pick_code();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 20) return 8'($urandom_range(0, 12));
    if (sel < 30) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(pick_code(), pick_code(), pick_code(), $urandom_range(0, 15) == 0);
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(snk_gaps && $urandom_range(0, 99) < 31);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_pixel(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tlast);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result({out_tdata[14:0], out_tdata[29:15], out_tdata[44:30], out_tlast});
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_STOP) begin
      $display("[srgb_to_xyz_pixel] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (CORNERS[i]) begin
      send_pixel(CORNERS[i][7:0], CORNERS[i][15:8], CORNERS[i][23:16], CORNERS[i][24]);
    end

    send_random(150);

    src_gaps = 1'b0;
    snk_gaps = 1'b0;
    send_random(100);

    // output held off while pixels keep coming: pipeline fills, input stalls
    hold_reqs++;
    send_random(60);

    src_gaps = 1'b1;
    snk_gaps = 1'b1;
    send_random(140);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    // let the last accepted beat reach the scoreboard first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[srgb_to_xyz_pixel] OK");
    end else begin
      $display("[srgb_to_xyz_pixel] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/s2xyz_pkg.sv
src/s2xyz_lin.sv
src/s2xyz_mac.sv
src/s2xyz_scale.sv
src/srgb_to_xyz_pixel.sv
tb/sv/srgb_to_xyz_pixel_tb.sv
